FILE: rtl/expression_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// expression_tokenizer_defines
// Assertion macros used by the tokenizer queue. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_TOKENIZER_DEFINES_SVH
`define EXPRESSION_TOKENIZER_DEFINES_SVH

`ifndef SYNTH
// Property that must hold on every clock edge outside reset
`define EXPTOK_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next
`define EXPTOK_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) else $error(msg);
`else
`define EXPTOK_ASSERT(name, prop, msg)
`define EXPTOK_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

FILE: rtl/exptok_pkg.sv
// ----------------------------------------------------------------------------
// exptok_pkg
// Token kinds, error codes, record types and character helpers.
// ----------------------------------------------------------------------------
package exptok_pkg;

    localparam int EXPTOK_OFFSET_BITS   = 16;
    localparam int EXPTOK_MAX_TOKEN_LEN = 255;
    localparam int EXPTOK_QUEUE_DEPTH   = 4;

    localparam logic [3:0] KIND_ID     = 4'd0;
    localparam logic [3:0] KIND_PRINT  = 4'd1;
    localparam logic [3:0] KIND_NUM    = 4'd2;
    localparam logic [3:0] KIND_DEFINE = 4'd3;
    localparam logic [3:0] KIND_NOTEQ  = 4'd4;
    localparam logic [3:0] KIND_COMMA  = 4'd5;
    localparam logic [3:0] KIND_LPAREN = 4'd6;
    localparam logic [3:0] KIND_RPAREN = 4'd7;
    localparam logic [3:0] KIND_ADD    = 4'd8;
    localparam logic [3:0] KIND_SUB    = 4'd9;
    localparam logic [3:0] KIND_MUL    = 4'd10;
    localparam logic [3:0] KIND_DIV    = 4'd11;
    localparam logic [3:0] KIND_SEMI   = 4'd12;
    localparam logic [3:0] KIND_EOF    = 4'd13;
    localparam logic [3:0] KIND_ERROR  = 4'd14;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_DEFINE = 2'd1;
    localparam logic [1:0] ERR_NOTEQ  = 2'd2;
    localparam logic [1:0] ERR_CHAR   = 2'd3;

    // keyword matcher: 0..4 still matching, 5 full match, 7 miss
    localparam logic [2:0] KW_LEN  = 3'd5;
    localparam logic [2:0] KW_MISS = 3'd7;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BANG  = 8'h21;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [7:0]  length;
        logic [1:0]  code;
    } exptok_rec_t;

    // all records caused by one input byte, oldest in rec[0]
    typedef struct packed {
        logic [1:0]            count;
        exptok_rec_t [2:0]     rec;
    } exptok_bundle_t;

    function automatic exptok_rec_t make_rec(input logic [3:0] kind,
                                             input logic [15:0] start,
                                             input logic [7:0] length,
                                             input logic [1:0] code);
        exptok_rec_t r;
        r.kind   = kind;
        r.start  = start;
        r.length = length;
        r.code   = code;
        return r;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h70; // p
            3'd1:    ch = 8'h72; // r
            3'd2:    ch = 8'h69; // i
            3'd3:    ch = 8'h6E; // n
            3'd4:    ch = 8'h74; // t
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // KIND_ERROR when the byte is not a one-byte symbol
    function automatic logic [3:0] symbol_kind(input logic [7:0] ch);
        logic [3:0] k;
        case (ch)
            8'h2C:   k = KIND_COMMA;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h2B:   k = KIND_ADD;
            8'h2D:   k = KIND_SUB;
            8'h2A:   k = KIND_MUL;
            8'h2F:   k = KIND_DIV;
            8'h3B:   k = KIND_SEMI;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/exptok_front.sv
// ----------------------------------------------------------------------------
// exptok_front
// Scanner: classifies each byte, tracks the open token and builds the
// bundle of records that byte causes.
// ----------------------------------------------------------------------------
module exptok_front #(
    parameter int OFFSET_BITS   = exptok_pkg::EXPTOK_OFFSET_BITS,
    parameter int MAX_TOKEN_LEN = exptok_pkg::EXPTOK_MAX_TOKEN_LEN
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_char_byte,
    input  logic                       s_end_of_text,
    input  logic                       q_full,
    output logic                       q_push,
    output exptok_pkg::exptok_bundle_t q_push_data
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_ID,
        MODE_NUM,
        MODE_COLON,
        MODE_BANG
    } mode_t;

    mode_t                  mode_reg,    mode_next;
    logic [OFFSET_BITS-1:0] offset_reg,  offset_next;
    logic [OFFSET_BITS-1:0] start_reg,   start_next;
    logic [LEN_W-1:0]       len_reg,     len_next;
    logic [2:0]             kw_reg,      kw_next;
    logic                   halted_reg,  halted_next;

    logic                   accept;
    logic                   rec_a_v, rec_m_v, rec_d_v;
    exptok_pkg::exptok_rec_t rec_a, rec_m, rec_d;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        logic [7:0]             c;
        logic                   is_alpha, is_digit, is_ws, taken, halt_now;
        logic [3:0]             sym;
        logic [OFFSET_BITS-1:0] pos_inc;
        logic [LEN_W-1:0]       len_grow;
        logic [2:0]             kw_step;

        c        = s_char_byte;
        is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
        is_digit = (c >= 8'h30 && c <= 8'h39);
        is_ws    = (c == exptok_pkg::CH_SPACE) || (c == exptok_pkg::CH_TAB) ||
                   (c == exptok_pkg::CH_CR) || (c == exptok_pkg::CH_LF);
        sym      = exptok_pkg::symbol_kind(c);
        pos_inc  = offset_reg + OFFSET_BITS'(1);
        len_grow = (len_reg < LEN_W'(MAX_TOKEN_LEN)) ? len_reg + LEN_W'(1) : len_reg;
        kw_step  = (kw_reg < exptok_pkg::KW_LEN && c == exptok_pkg::kw_char(kw_reg)) ?
                   kw_reg + 3'd1 : exptok_pkg::KW_MISS;

        mode_next   = mode_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        kw_next     = kw_reg;
        halted_next = halted_reg;
        taken       = 1'b0;
        halt_now    = 1'b0;
        rec_a_v     = 1'b0;
        rec_m_v     = 1'b0;
        rec_d_v     = 1'b0;
        rec_a       = '0;
        rec_m       = '0;
        rec_d       = '0;

        // continue or close the open token
        case (mode_reg)
            MODE_ID: begin
                if (is_alpha || is_digit) begin
                    len_next = len_grow;
                    kw_next  = kw_step;
                    taken    = 1'b1;
                end else begin
                    rec_a_v   = 1'b1;
                    rec_a     = exptok_pkg::make_rec(
                        (kw_reg == exptok_pkg::KW_LEN) ? exptok_pkg::KIND_PRINT :
                                                         exptok_pkg::KIND_ID,
                        16'(start_reg), 8'(len_reg), exptok_pkg::ERR_NONE);
                    mode_next = MODE_IDLE;
                    len_next  = '0;
                    kw_next   = '0;
                end
            end
            MODE_NUM: begin
                if (is_digit) begin
                    len_next = len_grow;
                    taken    = 1'b1;
                end else begin
                    rec_a_v   = 1'b1;
                    rec_a     = exptok_pkg::make_rec(exptok_pkg::KIND_NUM, 16'(start_reg),
                                                     8'(len_reg), exptok_pkg::ERR_NONE);
                    mode_next = MODE_IDLE;
                    len_next  = '0;
                    kw_next   = '0;
                end
            end
            MODE_COLON, MODE_BANG: begin
                rec_a_v   = 1'b1;
                mode_next = MODE_IDLE;
                len_next  = '0;
                if (c == exptok_pkg::CH_EQ) begin
                    rec_a = exptok_pkg::make_rec(
                        (mode_reg == MODE_COLON) ? exptok_pkg::KIND_DEFINE :
                                                   exptok_pkg::KIND_NOTEQ,
                        16'(start_reg), 8'd2, exptok_pkg::ERR_NONE);
                    taken = 1'b1;
                end else begin
                    // lone ':' or '!': report, drop it, rescan this byte
                    rec_a   = exptok_pkg::make_rec(exptok_pkg::KIND_ERROR, 16'(start_reg),
                        8'd1, (mode_reg == MODE_COLON) ? exptok_pkg::ERR_DEFINE :
                                                         exptok_pkg::ERR_NOTEQ);
                    kw_next = '0;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase

        // start something new with this byte
        if (!taken) begin
            if (is_ws) begin
                mode_next = mode_next;
            end else if (is_alpha) begin
                mode_next  = MODE_ID;
                start_next = offset_reg;
                len_next   = LEN_W'(1);
                kw_next    = (c == exptok_pkg::kw_char(3'd0)) ? 3'd1 : exptok_pkg::KW_MISS;
            end else if (is_digit) begin
                mode_next  = MODE_NUM;
                start_next = offset_reg;
                len_next   = LEN_W'(1);
                kw_next    = '0;
            end else if (c == exptok_pkg::CH_COLON || c == exptok_pkg::CH_BANG) begin
                mode_next  = (c == exptok_pkg::CH_COLON) ? MODE_COLON : MODE_BANG;
                start_next = offset_reg;
                len_next   = LEN_W'(1);
                kw_next    = '0;
            end else if (sym != exptok_pkg::KIND_ERROR) begin
                rec_m_v = 1'b1;
                rec_m   = exptok_pkg::make_rec(sym, 16'(offset_reg), 8'd1,
                                               exptok_pkg::ERR_NONE);
            end else begin
                rec_m_v     = 1'b1;
                rec_m       = exptok_pkg::make_rec(exptok_pkg::KIND_ERROR, 16'(offset_reg),
                                                   8'd1, exptok_pkg::ERR_CHAR);
                halt_now    = 1'b1;
                halted_next = 1'b1;
            end
        end

        // end of text: close what is still open, then the eof record
        if (!halt_now) begin
            if (s_end_of_text) begin
                case (mode_next)
                    MODE_ID: begin
                        rec_m_v = 1'b1;
                        rec_m   = exptok_pkg::make_rec(
                            (kw_next == exptok_pkg::KW_LEN) ? exptok_pkg::KIND_PRINT :
                                                              exptok_pkg::KIND_ID,
                            16'(start_next), 8'(len_next), exptok_pkg::ERR_NONE);
                    end
                    MODE_NUM: begin
                        rec_m_v = 1'b1;
                        rec_m   = exptok_pkg::make_rec(exptok_pkg::KIND_NUM, 16'(start_next),
                                                       8'(len_next), exptok_pkg::ERR_NONE);
                    end
                    MODE_COLON: begin
                        rec_m_v = 1'b1;
                        rec_m   = exptok_pkg::make_rec(exptok_pkg::KIND_ERROR,
                            16'(start_next), 8'd1, exptok_pkg::ERR_DEFINE);
                    end
                    MODE_BANG: begin
                        rec_m_v = 1'b1;
                        rec_m   = exptok_pkg::make_rec(exptok_pkg::KIND_ERROR,
                            16'(start_next), 8'd1, exptok_pkg::ERR_NOTEQ);
                    end
                    default: rec_m_v = rec_m_v;
                endcase
                mode_next   = MODE_IDLE;
                len_next    = '0;
                kw_next     = '0;
                rec_d_v     = 1'b1;
                rec_d       = exptok_pkg::make_rec(exptok_pkg::KIND_EOF, 16'(pos_inc), 8'd0,
                                                   exptok_pkg::ERR_NONE);
                offset_next = '0;
                start_next  = '0;
            end else begin
                offset_next = pos_inc;
            end
        end

        q_push_data.count  = 2'(rec_a_v) + 2'(rec_m_v) + 2'(rec_d_v);
        q_push_data.rec[0] = rec_a_v ? rec_a : (rec_m_v ? rec_m : rec_d);
        q_push_data.rec[1] = (rec_a_v && rec_m_v) ? rec_m : rec_d;
        q_push_data.rec[2] = rec_d;
        q_push = accept && !halted_reg && (q_push_data.count != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            offset_reg <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            kw_reg     <= '0;
            halted_reg <= 1'b0;
        end else if (accept && !halted_reg) begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            kw_reg     <= kw_next;
            halted_reg <= halted_next;
        end
    end

endmodule

FILE: rtl/exptok_queue.sv
// ----------------------------------------------------------------------------
// exptok_queue
// Short queue of record bundles between the scanner and the output stage.
// ----------------------------------------------------------------------------
`include "expression_tokenizer_defines.svh"

module exptok_queue #(
    parameter int DEPTH = exptok_pkg::EXPTOK_QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  exptok_pkg::exptok_bundle_t push_data,
    input  logic                       pop,
    output exptok_pkg::exptok_bundle_t head_data,
    output logic                       empty,
    output logic                       full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    exptok_pkg::exptok_bundle_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `EXPTOK_ASSERT(a_no_push_full, !(push && full), "push into full queue")
    `EXPTOK_ASSERT(a_no_pop_empty, !(pop && empty), "pop from empty queue")
    `EXPTOK_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count overflow")
    `EXPTOK_ASSERT(a_no_empty_bundle, !push || (push_data.count != 2'd0), "empty bundle pushed")
    `EXPTOK_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after push")

endmodule

FILE: rtl/exptok_back.sv
// ----------------------------------------------------------------------------
// exptok_back
// Output stage: walks the records of the head bundle into the result
// register, one per transaction, and flags the last one with run_end.
// ----------------------------------------------------------------------------
module exptok_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_empty,
    input  exptok_pkg::exptok_bundle_t q_head,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [3:0]                 m_token_kind,
    output logic [15:0]                m_token_start,
    output logic [7:0]                 m_token_length,
    output logic [1:0]                 m_error_code,
    output logic                       m_run_end
);

    logic                    valid_reg;
    logic [1:0]              idx_reg;
    exptok_pkg::exptok_rec_t rec_reg;
    logic                    run_end_reg;
    logic                    load;
    logic                    last_rec;
    exptok_pkg::exptok_rec_t sel_rec;

    assign load     = !q_empty && (!valid_reg || m_ready);
    assign last_rec = (idx_reg == q_head.count - 2'd1);
    assign q_pop    = load && last_rec;

    always_comb begin
        case (idx_reg)
            2'd1:    sel_rec = q_head.rec[1];
            2'd2:    sel_rec = q_head.rec[2];
            default: sel_rec = q_head.rec[0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= last_rec ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg     <= sel_rec;
            run_end_reg <= last_rec;
        end
    end

    assign m_valid        = valid_reg;
    assign m_token_kind   = rec_reg.kind;
    assign m_token_start  = rec_reg.start;
    assign m_token_length = rec_reg.length;
    assign m_error_code   = rec_reg.code;
    assign m_run_end      = run_end_reg;

endmodule

FILE: rtl/expression_tokenizer.sv
// A byte's first record passes through a queue slot and then the registered output
// stage before it reaches the outputs.
// Throughput: one byte per cycle while each byte yields at most one record and m_ready
// stays high; a byte with several records holds the single output register for one
// transaction each, while the QUEUE_DEPTH-entry bundle queue lets input run ahead.
// Reset (aresetn low, synchronous): scanner idle at offset 0, queue and output emptied.
// ----------------------------------------------------------------------------
// expression_tokenizer
// Streaming lexer: byte scanner, bundle queue and record output stage.
// An unexpected character halts the scanner until the next reset.
// ----------------------------------------------------------------------------
module expression_tokenizer #(
    parameter int OFFSET_BITS   = exptok_pkg::EXPTOK_OFFSET_BITS,
    parameter int MAX_TOKEN_LEN = exptok_pkg::EXPTOK_MAX_TOKEN_LEN,
    parameter int QUEUE_DEPTH   = exptok_pkg::EXPTOK_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [15:0] m_token_start,
    output logic [7:0]  m_token_length,
    output logic [1:0]  m_error_code,
    output logic        m_run_end
);

    logic                       q_full;
    logic                       q_empty;
    logic                       q_push;
    logic                       q_pop;
    exptok_pkg::exptok_bundle_t q_push_data;
    exptok_pkg::exptok_bundle_t q_head;

    exptok_front #(
        .OFFSET_BITS   (OFFSET_BITS),
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_byte   (s_char_byte),
        .s_end_of_text (s_end_of_text),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    exptok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    exptok_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_error_code   (m_error_code),
        .m_run_end      (m_run_end)
    );

endmodule

FILE: dv/expression_tokenizer_test.sv
// ----------------------------------------------------------------------------
// expression_tokenizer_test
// Streams source text into the tokenizer and checks every token record
// against an in-bench lexer. It covers directed text, random token streams,
// the keyword and its near misses, and the halt on a bad byte.
// ----------------------------------------------------------------------------
module expression_tokenizer_test;
    import exptok_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       hold;   // wait for all outstanding tokens before sending
    } text_byte_t;

    typedef struct packed {
        exptok_rec_t rec;
        logic        last;
    } token_record_t;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_COLON,
        SCAN_BANG
    } scan_state_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_byte = 8'h00;
    logic        s_end_of_text = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_token_kind;
    logic [15:0] m_token_start;
    logic [7:0]  m_token_length;
    logic [1:0]  m_error_code;
    logic        m_run_end;

    text_byte_t    pending_bytes[$];
    token_record_t expected_tokens[$];
    int            error_count = 0;
    int            tx_idle_pct = 13;
    int            rx_idle_pct = 57;

    // lexer state
    scan_state_t scan_state = SCAN_IDLE;
    logic [15:0] byte_pos = 16'd0;
    logic [15:0] tok_start = 16'd0;
    logic [7:0]  tok_len = 8'd0;
    logic [2:0]  kw_pos = 3'd0;
    bit          halted = 1'b0;
    string       kw_text = "print";

    expression_tokenizer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_error_code   (m_error_code),
        .m_run_end      (m_run_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_letter(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic logic [3:0] symbol_token_kind(input logic [7:0] ch);
        case (ch)
            ",":     return KIND_COMMA;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "+":     return KIND_ADD;
            "-":     return KIND_SUB;
            "*":     return KIND_MUL;
            "/":     return KIND_DIV;
            ";":     return KIND_SEMI;
            default: return KIND_ERROR;
        endcase
    endfunction

    task automatic add_token(input logic [3:0] kind, input logic [15:0] start,
                             input logic [7:0] len, input logic [1:0] code);
        token_record_t t;
        t.rec.kind   = kind;
        t.rec.start  = start;
        t.rec.length = len;
        t.rec.code   = code;
        t.last       = 1'b0;
        expected_tokens.push_back(t);
    endtask

    task automatic match_keyword(input logic [7:0] ch);
        if (kw_pos < KW_LEN && ch == kw_text[kw_pos])
            kw_pos++;
        else
            kw_pos = KW_MISS;
    endtask

    task automatic close_token();
        case (scan_state)
            SCAN_IDENT:
                add_token((kw_pos == KW_LEN) ? KIND_PRINT : KIND_ID, tok_start, tok_len,
                          ERR_NONE);
            SCAN_NUMBER: add_token(KIND_NUM, tok_start, tok_len, ERR_NONE);
            SCAN_COLON:  add_token(KIND_ERROR, tok_start, 8'd1, ERR_DEFINE);
            SCAN_BANG:   add_token(KIND_ERROR, tok_start, 8'd1, ERR_NOTEQ);
            default: ;
        endcase
        scan_state = SCAN_IDLE;
        tok_len    = 8'd0;
        kw_pos     = 3'd0;
    endtask

    task automatic open_token(input scan_state_t st, input logic [15:0] pos);
        scan_state = st;
        tok_start  = pos;
        tok_len    = 8'd1;
        kw_pos     = 3'd0;
    endtask

    // Expected token records for one accepted byte
    task automatic predict_tokens(input logic [7:0] ch, input logic eot);
        int          first;
        logic [15:0] pos;
        bit          taken;
        logic [3:0]  sym;
        first = expected_tokens.size();
        pos   = byte_pos;
        taken = 1'b0;
        sym   = symbol_token_kind(ch);
        if (halted)
            return;
        case (scan_state)
            SCAN_IDENT: begin
                if (is_letter(ch) || is_digit(ch)) begin
                    if (tok_len < EXPTOK_MAX_TOKEN_LEN)
                        tok_len++;
                    match_keyword(ch);
                    taken = 1'b1;
                end else begin
                    close_token();
                end
            end
            SCAN_NUMBER: begin
                if (is_digit(ch)) begin
                    if (tok_len < EXPTOK_MAX_TOKEN_LEN)
                        tok_len++;
                    taken = 1'b1;
                end else begin
                    close_token();
                end
            end
            SCAN_COLON, SCAN_BANG: begin
                if (ch == CH_EQ) begin
                    add_token((scan_state == SCAN_COLON) ? KIND_DEFINE : KIND_NOTEQ,
                              tok_start, 8'd2, ERR_NONE);
                    scan_state = SCAN_IDLE;
                    tok_len    = 8'd0;
                    taken      = 1'b1;
                end else begin
                    close_token();
                end
            end
            default: ;
        endcase
        if (!taken) begin
            if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF) begin
            end else if (is_letter(ch)) begin
                open_token(SCAN_IDENT, pos);
                match_keyword(ch);
            end else if (is_digit(ch)) begin
                open_token(SCAN_NUMBER, pos);
            end else if (ch == CH_COLON) begin
                open_token(SCAN_COLON, pos);
            end else if (ch == CH_BANG) begin
                open_token(SCAN_BANG, pos);
            end else if (sym != KIND_ERROR) begin
                add_token(sym, pos, 8'd1, ERR_NONE);
            end else begin
                // bad byte: open token already flushed, scanner stops for good
                add_token(KIND_ERROR, pos, 8'd1, ERR_CHAR);
                halted = 1'b1;
            end
        end
        if (!halted) begin
            if (eot) begin
                close_token();
                add_token(KIND_EOF, pos + 16'd1, 8'd0, ERR_NONE);
                byte_pos  = 16'd0;
                tok_start = 16'd0;
            end else begin
                byte_pos = pos + 16'd1;
            end
        end
        if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic push_byte(input logic [7:0] ch, input bit eot, input bit hold);
        text_byte_t b;
        b.ch   = ch;
        b.eot  = eot;
        b.hold = hold;
        pending_bytes.push_back(b);
    endtask

    task automatic push_text(input string s, input bit eot_last, input bit hold_first);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], eot_last && i == s.len() - 1, hold_first && i == 0);
    endtask

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    // Random but mostly well-formed token stream with some lone ':' and '!'
    task automatic push_random_text(input int target);
        int         counted;
        int         len;
        bit         blank;
        bit         eot;
        bit         hold;
        string      word;
        string      symbols;
        string      blanks;
        logic [7:0] lex[$];
        counted = 0;
        symbols = ",()+-*/;";
        blanks  = " \t\r\n";
        while (counted < target) begin
            lex.delete();
            blank = 1'b0;
            case ($urandom_range(0, 13))
                0, 1, 2: begin
                    len = $urandom_range(1, 9);
                    lex.push_back(rand_letter());
                    repeat (len - 1)
                        lex.push_back($urandom_range(0, 3) == 0 ? rand_digit() : rand_letter());
                end
                3: begin
                    case ($urandom_range(0, 3))
                        0:       word = "print";
                        1:       word = "prin";
                        2:       word = "printf";
                        default: word = "pRint";
                    endcase
                    for (int i = 0; i < word.len(); i++)
                        lex.push_back(word[i]);
                end
                4, 5: begin
                    repeat ($urandom_range(1, 5))
                        lex.push_back(rand_digit());
                end
                6, 7, 8: lex.push_back(symbols[$urandom_range(0, 7)]);
                9: begin
                    lex.push_back(CH_COLON);
                    lex.push_back(CH_EQ);
                end
                10: begin
                    lex.push_back(CH_BANG);
                    lex.push_back(CH_EQ);
                end
                11: lex.push_back($urandom_range(0, 1) ? CH_COLON : CH_BANG);
                default: begin
                    blank = 1'b1;
                    repeat ($urandom_range(1, 3))
                        lex.push_back(blanks[$urandom_range(0, 3)]);
                end
            endcase
            eot  = ($urandom_range(0, 11) == 0);
            hold = ($urandom_range(0, 49) == 0);
            for (int i = 0; i < lex.size(); i++)
                push_byte(lex[i], eot && i == lex.size() - 1, hold && i == 0);
            if (!blank)
                counted += lex.size();
            if ($urandom_range(0, 1))
                push_byte(blanks[$urandom_range(0, 3)], 1'b0, 1'b0);
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_valid || expected_tokens.size() != 0)
            @(posedge aclk);
    endtask

    // byte driver
    always @(posedge aclk) begin : drive_bytes
        text_byte_t nxt;
        bit         gap;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_tokens(s_char_byte, s_end_of_text);
            if (!s_valid || s_ready) begin
                gap = ($urandom_range(0, 99) < tx_idle_pct);
                if (pending_bytes.size() == 0 || gap ||
                    (pending_bytes[0].hold && expected_tokens.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    nxt = pending_bytes.pop_front();
                    s_valid       <= 1'b1;
                    s_char_byte   <= nxt.ch;
                    s_end_of_text <= nxt.eot;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // token monitor
    always @(posedge aclk) begin : check_tokens
        token_record_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d start %0d",
                                          m_token_kind, m_token_start));
            end else begin
                want = expected_tokens.pop_front();
                if (m_token_kind !== want.rec.kind)
                    report_mismatch($sformatf("kind %0d, want %0d (start %0d)",
                                              m_token_kind, want.rec.kind, want.rec.start));
                if (m_token_start !== want.rec.start)
                    report_mismatch($sformatf("start %0d, want %0d",
                                              m_token_start, want.rec.start));
                if (m_token_length !== want.rec.length)
                    report_mismatch($sformatf("length %0d, want %0d (start %0d)",
                                              m_token_length, want.rec.length,
                                              want.rec.start));
                if (m_error_code !== want.rec.code)
                    report_mismatch($sformatf("error code %0d, want %0d (start %0d)",
                                              m_error_code, want.rec.code, want.rec.start));
                if (m_run_end !== want.last)
                    report_mismatch($sformatf("run_end %0b, want %0b (start %0d)",
                                              m_run_end, want.last, want.rec.start));
            end
        end
    end

    initial begin
        // directed: keyword, all symbols, := != and lone : !, tab CR LF blanks,
        // end of text on a symbol and end of text closing an open ':'
        push_text("print(x9,0)+-*/;", 1'b0, 1'b0);
        push_text(":=!=:\t!\r\n", 1'b0, 1'b0);
        push_text("ab+", 1'b1, 1'b0);
        push_text(":", 1'b1, 1'b0);
        push_random_text(60);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        wait_drained();

        @(negedge aclk);
        tx_idle_pct = 57;
        rx_idle_pct = 13;
        push_text(" 5", 1'b0, 1'b1);
        push_random_text(60);
        wait_drained();

        @(negedge aclk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_random_text(60);
        // bad byte flushes the open token and halts; later bytes yield nothing
        push_text(" tok", 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_text("a", 1'b1, 1'b0);
        wait_drained();

        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/exptok_pkg.sv
rtl/exptok_front.sv
rtl/exptok_queue.sv
rtl/exptok_back.sv
rtl/expression_tokenizer.sv
dv/expression_tokenizer_test.sv
